// ----- src/udppd_pkg.sv -----
package udppd_pkg;

    // Sizing
    localparam int TABLE_ENTRIES = 64;
    localparam int PEER_COUNT    = 8;
    localparam int GROUP_SIZE    = 8;
    localparam int GROUP_COUNT   = (TABLE_ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int QUEUE_DEPTH   = 4;

    // Byte counter, saturating at all ones
    localparam int POS_W = 11;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    // Header geometry
    localparam logic [4:0]  ETH_HDR      = 5'd14;
    localparam logic [4:0]  VLAN_HDR     = 5'd18;
    localparam logic [11:0] ET_POS       = 12'd12;
    localparam logic [11:0] VLAN_ET_POS  = 12'd16;
    localparam logic [6:0]  V4_MIN_HDR   = 7'd20;
    localparam logic [6:0]  V6_HDR       = 7'd40;
    localparam logic [11:0] V4_PROTO_OFS = 12'd9;
    localparam logic [11:0] V6_NEXT_OFS  = 12'd6;
    localparam logic [11:0] UDP_DPORT_HI = 12'd2;
    localparam logic [11:0] UDP_DPORT_LO = 12'd3;
    localparam logic [11:0] UDP_HDR      = 12'd8;

    localparam logic [15:0] ET_VLAN   = 16'h8100;
    localparam logic [15:0] ET_IPV4   = 16'h0800;
    localparam logic [15:0] ET_IPV6   = 16'h86DD;
    localparam logic [7:0]  PROTO_UDP = 8'd17;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_V4,
        KIND_V6,
        KIND_OTHER
    } net_kind_t;

    typedef enum logic [2:0] {
        REASON_NONE,
        REASON_TRUNCATED,
        REASON_NOT_IP,
        REASON_NOT_UDP,
        REASON_UNKNOWN_PORT,
        REASON_PEER_ABSENT
    } pass_reason_t;

    typedef enum logic [1:0] {
        OP_TABLE_WRITE,
        OP_VERDICT,
        OP_LOOKUP
    } queue_op_t;

    // One queue transaction: a table write, a settled verdict or a verdict awaiting lookup
    typedef struct packed {
        queue_op_t    op;
        logic [5:0]   slot;
        logic [15:0]  port;
        logic [2:0]   peer;
        logic         entry_valid;
        pass_reason_t reason;
    } queue_entry_t;

    function automatic net_kind_t classify(input logic [15:0] et);
        net_kind_t kind;
        if (et == ET_IPV4)
        begin
            kind = KIND_V4;
        end
        else if (et == ET_IPV6)
        begin
            kind = KIND_V6;
        end
        else
        begin
            kind = KIND_OTHER;
        end
        return kind;
    endfunction

endpackage

// ----- src/udppd_item_if.sv -----
interface udppd_item_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [7:0]  frame_byte;
    logic        frame_last;
    logic [5:0]  table_slot;
    logic [15:0] entry_port;
    logic [2:0]  entry_peer;
    logic        entry_valid;

    modport source (
        output valid, cmd, frame_byte, frame_last, table_slot, entry_port, entry_peer,
               entry_valid,
        input  ready
    );
    modport sink (
        input  valid, cmd, frame_byte, frame_last, table_slot, entry_port, entry_peer,
               entry_valid,
        output ready
    );
endinterface

// ----- src/udppd_result_if.sv -----
interface udppd_result_if;
    logic        valid;
    logic        ready;
    logic        dispatch;
    logic [2:0]  peer_index;
    logic [15:0] dest_port;
    logic [2:0]  pass_reason;

    modport source (
        output valid, dispatch, peer_index, dest_port, pass_reason,
        input  ready
    );
    modport sink (
        input  valid, dispatch, peer_index, dest_port, pass_reason,
        output ready
    );
endinterface

// ----- src/udppd_front.sv -----
module udppd_front (
    input  logic                    clk,
    input  logic                    rst_n,
    udppd_item_if.sink              item,
    input  logic                    q_ready,
    output logic                    q_push,
    output udppd_pkg::queue_entry_t q_entry
);
    import udppd_pkg::*;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [15:0]      et_reg;
    logic [15:0]      et_next;
    logic [4:0]       ns_reg;
    logic [4:0]       ns_next;
    net_kind_t        kind_reg;
    net_kind_t        kind_next;
    logic [6:0]       ts_reg;
    logic [6:0]       ts_next;
    logic             udp_reg;
    logic             udp_next;
    logic [15:0]      pv_reg;
    logic [15:0]      pv_next;

    logic        accept;
    logic        byte_acc;
    logic [7:0]  b;
    logic [11:0] pos_ext;
    logic [11:0] ns_ext;
    logic [11:0] off;
    logic [11:0] ts_ext;
    logic [11:0] len;
    logic [11:0] ns_n_ext;
    logic [11:0] ts_n_ext;
    logic [6:0]  min_ts;
    logic [6:0]  min_ts_n;
    logic        hdr_byte;
    logic        ip_known;
    logic        need_lookup;
    pass_reason_t reason;

    assign item.ready = q_ready;
    assign accept     = item.valid && item.ready;
    assign byte_acc   = accept && !item.cmd;
    assign b          = item.frame_byte;
    assign pos_ext    = {1'b0, pos_reg};
    assign ns_ext     = {7'd0, ns_reg};
    assign off        = pos_ext - ns_ext;
    assign min_ts     = {2'd0, ns_reg} + V4_MIN_HDR;

    // Header field capture for the current byte
    always_comb
    begin
        et_next   = et_reg;
        ns_next   = ns_reg;
        kind_next = kind_reg;
        ts_next   = ts_reg;
        udp_next  = udp_reg;
        pv_next   = pv_reg;
        hdr_byte  = 1'b0;
        ip_known  = 1'b0;
        ts_ext    = '0;

        if (pos_ext == ET_POS + 12'd1)
        begin
            et_next[7:0] = b;
            if ({et_reg[15:8], b} == ET_VLAN)
            begin
                ns_next = VLAN_HDR;
            end
            else
            begin
                ns_next   = ETH_HDR;
                kind_next = classify({et_reg[15:8], b});
            end
        end
        else if (ns_reg == VLAN_HDR && pos_ext == VLAN_ET_POS + 12'd1)
        begin
            et_next[7:0] = b;
            kind_next    = classify({et_reg[15:8], b});
        end
        else
        begin
            if (pos_ext == ET_POS || (ns_reg == VLAN_HDR && pos_ext == VLAN_ET_POS))
            begin
                et_next[15:8] = b;
            end
            hdr_byte = (pos_ext >= ns_ext);
        end

        // Network header: transport offset and protocol
        if (hdr_byte)
        begin
            unique case (kind_reg)
                KIND_V4:
                begin
                    ip_known = 1'b1;
                    if (off == 12'd0)
                    begin
                        ts_next = {2'd0, ns_reg} + {3'd0, b[3:0]} * 7'd4;
                    end
                    if (off == V4_PROTO_OFS)
                    begin
                        udp_next = (b == PROTO_UDP);
                    end
                end
                KIND_V6:
                begin
                    ip_known = 1'b1;
                    if (off == 12'd0)
                    begin
                        ts_next = {2'd0, ns_reg} + V6_HDR;
                    end
                    if (off == V6_NEXT_OFS)
                    begin
                        udp_next = (b == PROTO_UDP);
                    end
                end
                default:
                begin
                    ip_known = 1'b0;
                end
            endcase
        end

        // UDP destination port
        ts_ext = {5'd0, ts_next};
        if (ip_known && udp_next && ts_next >= min_ts)
        begin
            if (pos_ext == ts_ext + UDP_DPORT_HI)
            begin
                pv_next[15:8] = b;
            end
            if (pos_ext == ts_ext + UDP_DPORT_LO)
            begin
                pv_next[7:0] = b;
            end
        end
    end

    // Verdict on the frame as it stands after this byte
    assign len      = pos_ext + 12'd1;
    assign ns_n_ext = {7'd0, ns_next};
    assign ts_n_ext = {5'd0, ts_next};
    assign min_ts_n = {2'd0, ns_next} + V4_MIN_HDR;

    always_comb
    begin
        need_lookup = 1'b0;
        priority if (len < {7'd0, ETH_HDR} || len < ns_n_ext)
        begin
            reason = REASON_TRUNCATED;
        end
        else if (kind_next != KIND_V4 && kind_next != KIND_V6)
        begin
            reason = REASON_NOT_IP;
        end
        else if (len < ns_n_ext + {5'd0, (kind_next == KIND_V4) ? V4_MIN_HDR : V6_HDR})
        begin
            reason = REASON_TRUNCATED;
        end
        else if (!udp_next)
        begin
            reason = REASON_NOT_UDP;
        end
        else if (ts_next < min_ts_n)
        begin
            reason = REASON_NOT_IP;
        end
        else if (len < ts_n_ext + UDP_HDR)
        begin
            reason = REASON_TRUNCATED;
        end
        else
        begin
            reason      = REASON_NONE;
            need_lookup = 1'b1;
        end
    end

    // Queue transaction
    assign q_push = accept && (item.cmd || item.frame_last);

    always_comb
    begin
        q_entry.slot        = item.table_slot;
        q_entry.peer        = item.entry_peer;
        q_entry.entry_valid = item.entry_valid;
        if (item.cmd)
        begin
            q_entry.op     = OP_TABLE_WRITE;
            q_entry.port   = item.entry_port;
            q_entry.reason = REASON_NONE;
        end
        else
        begin
            q_entry.op     = need_lookup ? OP_LOOKUP : OP_VERDICT;
            q_entry.port   = need_lookup ? pv_next : 16'd0;
            q_entry.reason = reason;
        end
    end

    assign pos_next = (pos_reg == POS_MAX) ? pos_reg : pos_reg + POS_W'(1);

    // Frame state; cleared after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            et_reg   <= '0;
            ns_reg   <= ETH_HDR;
            kind_reg <= KIND_NONE;
            ts_reg   <= '0;
            udp_reg  <= 1'b0;
            pv_reg   <= '0;
        end
        else if (byte_acc)
        begin
            if (item.frame_last)
            begin
                pos_reg  <= '0;
                et_reg   <= '0;
                ns_reg   <= ETH_HDR;
                kind_reg <= KIND_NONE;
                ts_reg   <= '0;
                udp_reg  <= 1'b0;
                pv_reg   <= '0;
            end
            else
            begin
                pos_reg  <= pos_next;
                et_reg   <= et_next;
                ns_reg   <= ns_next;
                kind_reg <= kind_next;
                ts_reg   <= ts_next;
                udp_reg  <= udp_next;
                pv_reg   <= pv_next;
            end
        end
    end

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        byte_acc && item.frame_last |=> pos_reg == '0 && kind_reg == KIND_NONE)
        else $error("frame state not cleared after last byte");

endmodule

// ----- src/udppd_queue.sv -----
module udppd_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  udppd_pkg::queue_entry_t push_entry,
    output logic                    push_ready,
    input  logic                    pop,
    output logic                    pop_valid,
    output udppd_pkg::queue_entry_t pop_entry
);
    import udppd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    queue_entry_t     entry_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;

    assign push_ready = (count_reg != (PTR_W+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = entry_mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (PTR_W+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (PTR_W+1)'(1);
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_mem[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PTR_W+1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0 && count_reg != (PTR_W+1)'(QUEUE_DEPTH)
            |-> wr_ptr_reg - rd_ptr_reg == count_reg[PTR_W-1:0])
        else $error("queue pointers disagree with count");

endmodule

// ----- src/udppd_back.sv -----
module udppd_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    input  udppd_pkg::queue_entry_t q_entry,
    output logic                    q_pop,
    input  logic [7:0]              peer_mask,
    udppd_result_if.source          result
);
    import udppd_pkg::*;

    // Port table
    logic        tab_valid_reg [TABLE_ENTRIES];
    logic [15:0] tab_port_reg  [TABLE_ENTRIES];
    logic [2:0]  tab_peer_reg  [TABLE_ENTRIES];

    logic back_en;
    logic tab_write;

    logic [GROUP_SIZE-1:0] match [GROUP_COUNT];
    logic [2:0]            cand_peer [GROUP_COUNT][GROUP_SIZE];
    logic                  grp_hit_next  [GROUP_COUNT];
    logic [2:0]            grp_peer_next [GROUP_COUNT];

    // Compare stage registers
    logic         s1_vld_reg;
    logic         s1_lookup_reg;
    logic [15:0]  s1_port_reg;
    pass_reason_t s1_reason_reg;
    logic         s1_hit_reg  [GROUP_COUNT];
    logic [2:0]   s1_peer_reg [GROUP_COUNT];

    logic         hit;
    logic [2:0]   hit_peer;

    // Output register
    logic         out_vld_reg;
    logic         out_disp_reg;
    logic         out_disp_next;
    logic [2:0]   out_peer_reg;
    logic [2:0]   out_peer_next;
    logic [15:0]  out_port_reg;
    pass_reason_t out_reason_reg;
    pass_reason_t out_reason_next;

    assign back_en   = !out_vld_reg || result.ready;
    assign q_pop     = q_valid && back_en;
    assign tab_write = q_pop && (q_entry.op == OP_TABLE_WRITE);

    // Table entries; a slot beyond the table matches no entry and is dropped
    genvar gi;
    genvar gk;
    generate
        for (gi = 0; gi < TABLE_ENTRIES; gi++)
        begin : g_entry
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    tab_valid_reg[gi] <= 1'b0;
                end
                else if (tab_write && {3'd0, q_entry.slot} == 9'(gi))
                begin
                    tab_valid_reg[gi] <= q_entry.entry_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                if (tab_write && {3'd0, q_entry.slot} == 9'(gi))
                begin
                    tab_port_reg[gi] <= q_entry.port;
                    tab_peer_reg[gi] <= q_entry.peer;
                end
            end
        end

        // Per-entry compare
        for (gi = 0; gi < GROUP_COUNT; gi++)
        begin : g_group
            for (gk = 0; gk < GROUP_SIZE; gk++)
            begin : g_slot
                if (gi * GROUP_SIZE + gk < TABLE_ENTRIES)
                begin : g_live
                    assign match[gi][gk] = tab_valid_reg[gi*GROUP_SIZE+gk]
                        && (tab_port_reg[gi*GROUP_SIZE+gk] == q_entry.port);
                    assign cand_peer[gi][gk] = tab_peer_reg[gi*GROUP_SIZE+gk];
                end
                else
                begin : g_pad
                    assign match[gi][gk]     = 1'b0;
                    assign cand_peer[gi][gk] = 3'd0;
                end
            end
        end
    endgenerate

    // Lowest matching slot inside each group
    always_comb
    begin
        for (int g = 0; g < GROUP_COUNT; g++)
        begin
            grp_hit_next[g]  = |match[g];
            grp_peer_next[g] = 3'd0;
            for (int k = GROUP_SIZE - 1; k >= 0; k--)
            begin
                if (match[g][k])
                begin
                    grp_peer_next[g] = cand_peer[g][k];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (back_en)
        begin
            s1_vld_reg <= q_valid && (q_entry.op != OP_TABLE_WRITE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (back_en && q_valid)
        begin
            s1_lookup_reg <= (q_entry.op == OP_LOOKUP);
            s1_port_reg   <= q_entry.port;
            s1_reason_reg <= q_entry.reason;
            for (int g = 0; g < GROUP_COUNT; g++)
            begin
                s1_hit_reg[g]  <= grp_hit_next[g];
                s1_peer_reg[g] <= grp_peer_next[g];
            end
        end
    end

    // Lowest hitting group, then the peer presence check
    always_comb
    begin
        hit      = 1'b0;
        hit_peer = 3'd0;
        for (int g = GROUP_COUNT - 1; g >= 0; g--)
        begin
            if (s1_hit_reg[g])
            begin
                hit      = 1'b1;
                hit_peer = s1_peer_reg[g];
            end
        end

        out_disp_next   = 1'b0;
        out_peer_next   = 3'd0;
        out_reason_next = s1_reason_reg;
        if (s1_lookup_reg)
        begin
            if (!hit)
            begin
                out_reason_next = REASON_UNKNOWN_PORT;
            end
            else if ({1'b0, hit_peer} < 4'(PEER_COUNT) && peer_mask[hit_peer])
            begin
                out_disp_next   = 1'b1;
                out_peer_next   = hit_peer;
                out_reason_next = REASON_NONE;
            end
            else
            begin
                out_reason_next = REASON_PEER_ABSENT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (back_en)
        begin
            out_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (back_en && s1_vld_reg)
        begin
            out_disp_reg   <= out_disp_next;
            out_peer_reg   <= out_peer_next;
            out_port_reg   <= s1_port_reg;
            out_reason_reg <= out_reason_next;
        end
    end

    assign result.valid       = out_vld_reg;
    assign result.dispatch    = out_disp_reg;
    assign result.peer_index  = out_peer_reg;
    assign result.dest_port   = out_port_reg;
    assign result.pass_reason = out_reason_reg;

    a_disp_reason: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_disp_reg |-> out_reason_reg == REASON_NONE)
        else $error("dispatched verdict carries a pass reason");

    a_pass_peer: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !out_disp_reg |-> out_peer_reg == 3'd0
            && out_reason_reg != REASON_NONE)
        else $error("passed verdict has peer or no reason");

    a_stage_move: assert property (@(posedge clk) disable iff (!rst_n)
        back_en && s1_vld_reg |=> out_vld_reg)
        else $error("verdict lost between compare and output stages");

endmodule

// ----- src/udp_port_packet_dispatcher.sv -----
// Classifies frames byte by byte (Ethernet, one optional 802.1Q tag, IPv4 or
// IPv6, UDP) and gives one verdict per frame after its last byte: dispatch to
// the peer bound to the UDP destination port, or pass with a reason. Port-table
// writes travel through the same path, so they apply in order with respect to
// the frames around them. One transaction is taken every cycle while the
// four-entry queue between parser and lookup has room; a verdict leaves
// through the queue, the table compare stage and the output register once the
// last byte is taken. The table compare runs over all entries in parallel, with
// the lowest-slot priority resolved in two registered steps of eight. No
// clearing pass follows reset. peer_present_mask sits at byte address 0.
module udp_port_packet_dispatcher (
    input  logic            clk,
    input  logic            rst_n,
    udppd_item_if.sink      item,
    udppd_result_if.source  result,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);
    import udppd_pkg::*;

    logic [7:0]   mask_reg;
    logic         q_push;
    logic         q_ready;
    logic         q_pop;
    logic         q_valid;
    queue_entry_t q_in;
    queue_entry_t q_out;

    // Register port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {24'd0, mask_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == 1'b0)
        begin
            mask_reg <= pwdata[7:0];
        end
    end

    udppd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .q_ready (q_ready),
        .q_push  (q_push),
        .q_entry (q_in)
    );

    udppd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_entry  (q_out)
    );

    udppd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (q_out),
        .q_pop     (q_pop),
        .peer_mask (mask_reg),
        .result    (result)
    );

endmodule

// ----- tb/udp_port_packet_dispatcher_tb.sv -----
module udp_port_packet_dispatcher_tb;
    import udppd_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 12;
    localparam int RANDOM_ITEMS = 1300;

    localparam logic       CMD_FRAME      = 1'b0;
    localparam logic       CMD_TABLE      = 1'b1;
    localparam logic [2:0] ADDR_PEER_MASK = 3'd0;
    localparam logic [7:0] PROTO_TCP      = 8'd6;

    localparam int NET_V4    = 0;
    localparam int NET_V6    = 1;
    localparam int NET_OTHER = 2;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  frame_byte;
        logic        frame_last;
        logic [5:0]  slot;
        logic [15:0] port;
        logic [2:0]  peer;
        logic        entry_valid;
    } frame_item_t;

    typedef struct packed {
        logic         dispatch;
        logic [2:0]   peer;
        logic [15:0]  port;
        pass_reason_t reason;
    } verdict_t;

    // Tracks the parser and port table, and holds the verdicts still to come
    class dispatch_scoreboard;
        logic [7:0]  peer_mask;
        logic [10:0] pos;
        logic [15:0] eth_type;
        logic [4:0]  net_start;
        net_kind_t   kind;
        logic [6:0]  l4_start;
        bit          udp_seen;
        logic [15:0] dport_acc;
        bit          slot_used [TABLE_ENTRIES];
        logic [15:0] slot_port [TABLE_ENTRIES];
        logic [2:0]  slot_peer [TABLE_ENTRIES];
        verdict_t    verdicts_due[$];
        int          mismatches;
        int          verdicts_seen;

        function new();
            int i;
            peer_mask     = '0;
            mismatches    = 0;
            verdicts_seen = 0;
            for (i = 0; i < TABLE_ENTRIES; i++)
            begin
                slot_used[i] = 1'b0;
                slot_port[i] = '0;
                slot_peer[i] = '0;
            end
            clear_frame();
        endfunction

        function void clear_frame();
            pos       = '0;
            eth_type  = '0;
            net_start = ETH_HDR;
            kind      = KIND_NONE;
            l4_start  = '0;
            udp_seen  = 1'b0;
            dport_acc = '0;
        endfunction

        function net_kind_t kind_of(input logic [15:0] et);
            if (et == ET_IPV4)
                return KIND_V4;
            if (et == ET_IPV6)
                return KIND_V6;
            return KIND_OTHER;
        endfunction

        // Header field capture for the byte at position p
        function void parse_byte(input int p, input logic [7:0] b);
            int ns;
            int o;
            ns = int'(net_start);
            if (p == 12)
                eth_type[15:8] = b;
            if (p == 13)
            begin
                eth_type[7:0] = b;
                if (eth_type == ET_VLAN)
                    net_start = VLAN_HDR;
                else
                begin
                    net_start = ETH_HDR;
                    kind      = kind_of(eth_type);
                end
                return;
            end
            if (ns == 18 && p == 16)
                eth_type[15:8] = b;
            if (ns == 18 && p == 17)
            begin
                eth_type[7:0] = b;
                kind          = kind_of(eth_type);
                return;
            end
            if (p < ns)
                return;
            o = p - ns;
            if (kind == KIND_V4)
            begin
                if (o == 0)
                    l4_start = 7'(ns + int'(b[3:0]) * 4);
                if (o == 9)
                    udp_seen = (b == PROTO_UDP);
            end
            else if (kind == KIND_V6)
            begin
                if (o == 0)
                    l4_start = 7'(ns + 40);
                if (o == 6)
                    udp_seen = (b == PROTO_UDP);
            end
            else
                return;
            if (udp_seen && int'(l4_start) >= ns + 20)
            begin
                if (p == int'(l4_start) + 2)
                    dport_acc[15:8] = b;
                if (p == int'(l4_start) + 3)
                    dport_acc[7:0] = b;
            end
        endfunction

        // Verdict for a frame of len bytes, checks in header order
        function verdict_t decide_verdict(input int len);
            verdict_t v;
            int       ns;
            int       hit;
            int       i;
            v        = '0;
            v.reason = REASON_NONE;
            ns       = int'(net_start);
            hit      = -1;
            if (len < 14 || len < ns)
                v.reason = REASON_TRUNCATED;
            else if (kind != KIND_V4 && kind != KIND_V6)
                v.reason = REASON_NOT_IP;
            else if (len < ns + ((kind == KIND_V4) ? 20 : 40))
                v.reason = REASON_TRUNCATED;
            else if (!udp_seen)
                v.reason = REASON_NOT_UDP;
            else if (int'(l4_start) < ns + 20)
                v.reason = REASON_NOT_IP;
            else if (len < int'(l4_start) + 8)
                v.reason = REASON_TRUNCATED;
            else
            begin
                v.port = dport_acc;
                // lowest valid matching slot wins
                for (i = 0; i < TABLE_ENTRIES && hit < 0; i++)
                    if (slot_used[i] && slot_port[i] == dport_acc)
                        hit = i;
                if (hit < 0)
                    v.reason = REASON_UNKNOWN_PORT;
                else if (int'(slot_peer[hit]) < PEER_COUNT && peer_mask[slot_peer[hit]])
                begin
                    v.dispatch = 1'b1;
                    v.peer     = slot_peer[hit];
                end
                else
                    v.reason = REASON_PEER_ABSENT;
            end
            return v;
        endfunction

        // Accepted input transaction
        function void note_item(input frame_item_t it);
            int p;
            if (it.cmd == CMD_TABLE)
            begin
                if (int'(it.slot) < TABLE_ENTRIES)
                begin
                    slot_used[it.slot] = it.entry_valid;
                    slot_port[it.slot] = it.port;
                    slot_peer[it.slot] = it.peer;
                end
                return;
            end
            p = int'(pos);
            parse_byte(p, it.frame_byte);
            if (pos != POS_MAX)
                pos = pos + 1'b1;
            if (it.frame_last)
            begin
                verdicts_due.push_back(decide_verdict(p + 1));
                clear_frame();
            end
        endfunction

        function void report(input string field, input logic [15:0] want,
                             input logic [15:0] got_v);
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got_v);
            mismatches++;
        endfunction

        // Accepted result transaction
        function void check_verdict(input verdict_t got);
            verdict_t want;
            verdicts_seen++;
            if (verdicts_due.size() == 0)
            begin
                $display("%0t: unexpected verdict, expected none, actual %p", $time, got);
                mismatches++;
                return;
            end
            want = verdicts_due.pop_front();
            if (got.dispatch !== want.dispatch)
                report("dispatch", 16'(want.dispatch), 16'(got.dispatch));
            if (got.peer !== want.peer)
                report("peer_index", 16'(want.peer), 16'(got.peer));
            if (got.port !== want.port)
                report("dest_port", want.port, got.port);
            if (got.reason !== want.reason)
                report("pass_reason", 16'(want.reason), 16'(got.reason));
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    udppd_item_if   item_bus();
    udppd_result_if result_bus();

    dispatch_scoreboard board;
    logic [7:0]  frame_buf[$];
    logic [15:0] hot_port[8];
    bit          calm;
    int          items_sent;
    int          cycles;

    udp_port_packet_dispatcher u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_bus),
        .result  (result_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #5;
        clk = 1'b1;
        #5;
        clk = 1'b0;
    end

    // Watchdog
    initial
        cycles = 0;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 16);
    endfunction

    // One input transaction, waiting out the handshake
    task automatic send_item(input frame_item_t it);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_bus.valid       <= 1'b1;
        item_bus.cmd         <= it.cmd;
        item_bus.frame_byte  <= it.frame_byte;
        item_bus.frame_last  <= it.frame_last;
        item_bus.table_slot  <= it.slot;
        item_bus.entry_port  <= it.port;
        item_bus.entry_peer  <= it.peer;
        item_bus.entry_valid <= it.entry_valid;
        do
            @(posedge clk);
        while (item_bus.ready !== 1'b1);
        board.note_item(it);
        items_sent++;
    endtask

    // Unused fields carry noise
    task automatic send_byte(input logic [7:0] b, input logic last);
        frame_item_t it;
        it.cmd         = CMD_FRAME;
        it.frame_byte  = b;
        it.frame_last  = last;
        it.slot        = 6'($urandom);
        it.port        = 16'($urandom);
        it.peer        = 3'($urandom);
        it.entry_valid = 1'($urandom);
        send_item(it);
    endtask

    task automatic write_entry(input logic [5:0] slot, input logic [15:0] port,
                               input logic [2:0] peer, input logic entry_valid);
        frame_item_t it;
        it.cmd         = CMD_TABLE;
        it.frame_byte  = 8'($urandom);
        it.frame_last  = 1'($urandom);
        it.slot        = slot;
        it.port        = port;
        it.peer        = peer;
        it.entry_valid = entry_valid;
        send_item(it);
    endtask

    task automatic random_entry_write();
        logic [15:0] port;
        port = ($urandom_range(0, 3) != 0) ? hot_port[$urandom_range(0, 7)] : 16'($urandom);
        write_entry(6'($urandom), port, 3'($urandom), 1'($urandom_range(0, 4) != 0));
    endtask

    // Ethernet, optional tags, IP header, then a UDP header
    function automatic void build_frame(input int tags, input int net, input logic [7:0] proto,
                                        input logic [3:0] ihl, input logic [15:0] dport);
        int          i;
        logic [15:0] et;
        frame_buf.delete();
        for (i = 0; i < 12; i++)
            frame_buf.push_back(8'($urandom));
        for (i = 0; i < tags; i++)
        begin
            frame_buf.push_back(ET_VLAN[15:8]);
            frame_buf.push_back(ET_VLAN[7:0]);
            frame_buf.push_back(8'($urandom));
            frame_buf.push_back(8'($urandom));
        end
        if (net == NET_V4)
            et = ET_IPV4;
        else if (net == NET_V6)
            et = ET_IPV6;
        else
        begin
            et = 16'($urandom);
            if (et == ET_IPV4 || et == ET_IPV6 || et == ET_VLAN)
                et = 16'h0806;
        end
        frame_buf.push_back(et[15:8]);
        frame_buf.push_back(et[7:0]);
        if (net == NET_V4)
        begin
            frame_buf.push_back({4'($urandom), ihl});
            for (i = 1; i < 9; i++)
                frame_buf.push_back(8'($urandom));
            frame_buf.push_back(proto);
            for (i = 10; i < 20; i++)
                frame_buf.push_back(8'($urandom));
            for (i = 5; i < int'(ihl); i++)
                repeat (4) frame_buf.push_back(8'($urandom));
        end
        else if (net == NET_V6)
        begin
            for (i = 0; i < 6; i++)
                frame_buf.push_back(8'($urandom));
            frame_buf.push_back(proto);
            for (i = 7; i < 40; i++)
                frame_buf.push_back(8'($urandom));
        end
        frame_buf.push_back(8'($urandom));
        frame_buf.push_back(8'($urandom));
        frame_buf.push_back(dport[15:8]);
        frame_buf.push_back(dport[7:0]);
        repeat (4) frame_buf.push_back(8'($urandom));
    endfunction

    // Bytes [first, first+count) of the buffer; table writes may slip in between
    task automatic send_bytes(input int first, input int count, input bit ends);
        int i;
        for (i = first; i < first + count; i++)
        begin
            if ($urandom_range(0, 39) == 0)
                random_entry_write();
            send_byte(frame_buf[i], ends && (i == first + count - 1));
        end
    endtask

    task automatic send_frame(input int len);
        while (frame_buf.size() < len)
            frame_buf.push_back(8'($urandom));
        send_bytes(0, len, 1'b1);
    endtask

    task automatic send_whole(input int tags, input int net, input logic [7:0] proto,
                              input logic [3:0] ihl, input logic [15:0] dport);
        build_frame(tags, net, proto, ihl, dport);
        send_frame(frame_buf.size() + $urandom_range(0, 6));
    endtask

    // Mostly well-formed frames with random content, the rest broken
    task automatic random_frame();
        int          pick;
        int          tags;
        int          net;
        int          len;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [15:0] dport;
        calm  = ($urandom_range(0, 3) == 0);
        tags  = ($urandom_range(0, 3) == 0) ? 1 : 0;
        net   = $urandom_range(0, 1);
        ihl   = 4'd5;
        proto = PROTO_UDP;
        dport = hot_port[$urandom_range(0, 7)];
        pick  = $urandom_range(0, 19);
        case (pick)
            11: ihl = 4'($urandom_range(6, 15));
            12: ihl = 4'($urandom_range(0, 4));
            13: proto = 8'($urandom);
            14: net = NET_OTHER;
            15: tags = 2;
            16: dport = 16'($urandom);
            default: ;
        endcase
        build_frame(tags, net, proto, ihl, dport);
        len = frame_buf.size() + $urandom_range(0, 24);
        if (pick >= 17)
            len = $urandom_range(1, frame_buf.size());
        send_frame(len);
    endtask

    // Lets the block go quiet before a register write
    task automatic settle_block();
        item_bus.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_peer_mask(input logic [7:0] mask);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_PEER_MASK;
        pwdata  <= {24'd0, mask};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.peer_mask = mask;
    endtask

    // Result side: random back-pressure, check every accepted verdict
    initial
    begin : verdict_sink
        int       stall;
        verdict_t got;
        result_bus.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = draw_wait();
            if (stall > 0)
            begin
                result_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (result_bus.valid !== 1'b1);
            got.dispatch = result_bus.dispatch;
            got.peer     = result_bus.peer_index;
            got.port     = result_bus.dest_port;
            got.reason   = pass_reason_t'(result_bus.pass_reason);
            board.check_verdict(got);
        end
    end

    initial
    begin : stimulus
        int         start_items;
        int         phase;
        int         f;
        int         waited;
        logic [7:0] mask;
        board                = new();
        calm                 = 1'b0;
        items_sent           = 0;
        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        item_bus.valid       = 1'b0;
        item_bus.cmd         = CMD_FRAME;
        item_bus.frame_byte  = '0;
        item_bus.frame_last  = 1'b0;
        item_bus.table_slot  = '0;
        item_bus.entry_port  = '0;
        item_bus.entry_peer  = '0;
        item_bus.entry_valid = 1'b0;
        hot_port[0] = 16'h0000;
        hot_port[1] = 16'hFFFF;
        hot_port[2] = 16'd4789;
        hot_port[3] = 16'd53;
        for (f = 4; f < 8; f++)
            hot_port[f] = 16'($urandom);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: table at both ends, duplicate port, every verdict kind
        write_entry(6'd0, 16'hFFFF, 3'd7, 1'b1);
        write_entry(6'd63, 16'h0000, 3'd0, 1'b1);
        write_entry(6'd5, 16'd4789, 3'd2, 1'b1);
        write_entry(6'd3, 16'd53, 3'd1, 1'b1);
        write_entry(6'd10, 16'd53, 3'd6, 1'b1);
        // mask still clear after reset: peer absent
        send_whole(0, NET_V4, PROTO_UDP, 4'd5, 16'd4789);
        settle_block();
        write_peer_mask(8'hFF);

        build_frame(0, NET_V4, PROTO_UDP, 4'd5, 16'd4789);
        send_frame(1);
        build_frame(0, NET_V4, PROTO_UDP, 4'd5, 16'd4789);
        send_frame(13);
        build_frame(0, NET_V4, PROTO_UDP, 4'd5, 16'd4789);
        send_frame(14);
        send_whole(0, NET_OTHER, PROTO_UDP, 4'd5, 16'd4789);
        build_frame(1, NET_V4, PROTO_UDP, 4'd5, 16'd4789);
        send_frame(16);
        // second tag reads as a non-IP EtherType
        send_whole(2, NET_V4, PROTO_UDP, 4'd5, 16'd4789);
        send_whole(0, NET_V4, PROTO_TCP, 4'd5, 16'd4789);
        // short ihl: not IP, unless the protocol is not UDP
        send_whole(0, NET_V4, PROTO_UDP, 4'd4, 16'd4789);
        send_whole(0, NET_V4, PROTO_TCP, 4'd0, 16'd4789);
        send_whole(0, NET_V4, PROTO_UDP, 4'd15, 16'hFFFF);
        build_frame(0, NET_V4, PROTO_UDP, 4'd5, 16'd4789);
        send_frame(frame_buf.size() - 1);
        send_whole(0, NET_V6, PROTO_UDP, 4'd5, 16'h0000);
        send_whole(0, NET_V6, PROTO_TCP, 4'd5, 16'h0000);
        build_frame(0, NET_V6, PROTO_UDP, 4'd5, 16'h0000);
        send_frame(53);
        send_whole(1, NET_V6, PROTO_UDP, 4'd5, 16'd53);
        write_entry(6'd3, 16'd53, 3'd1, 1'b0);
        send_whole(1, NET_V4, PROTO_UDP, 4'd5, 16'd53);
        send_whole(0, NET_V4, PROTO_UDP, 4'd5, 16'd1234);
        // table write in the middle of a frame
        build_frame(0, NET_V4, PROTO_UDP, 4'd5, 16'd4321);
        send_bytes(0, 30, 1'b0);
        write_entry(6'd20, 16'd4321, 3'd5, 1'b1);
        send_bytes(30, frame_buf.size() - 30, 1'b1);
        // long frame, byte counter saturates
        calm = 1'b1;
        build_frame(0, NET_V4, PROTO_UDP, 4'd5, 16'd4789);
        send_frame(2100);
        calm = 1'b0;
        settle_block();
        write_peer_mask(8'h04);
        send_whole(0, NET_V4, PROTO_UDP, 4'd5, 16'hFFFF);
        send_whole(0, NET_V6, PROTO_UDP, 4'd5, 16'd4789);

        // Random phases, a new peer mask each
        start_items = items_sent;
        phase       = 0;
        while (items_sent - start_items < RANDOM_ITEMS)
        begin
            case (phase)
                0: mask = 8'h00;
                1: mask = 8'hFF;
                2: mask = 8'h5A;
                default: mask = 8'($urandom);
            endcase
            settle_block();
            write_peer_mask(mask);
            for (f = 0; f < 10; f++)
            begin
                repeat ($urandom_range(0, 2)) random_entry_write();
                random_frame();
            end
            phase++;
        end

        // Drain and report
        item_bus.valid <= 1'b0;
        for (waited = 0; waited < 5000 && board.pending() != 0; waited++)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.pending() != 0)
        begin
            $display("%0t: verdicts missing, expected %0d more, actual 0", $time,
                     board.pending());
            board.mismatches++;
        end
        if (board.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
